FILE: rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// TEA cipher engine package
// Shared widths, reset values, codes and control bundles of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned UPC_W     = 3;

    localparam logic [CNT_W-1:0] MAX_ROUNDS = 7'd64;

    // Register reset values
    localparam logic [WORD_W-1:0] KEY_A_RST       = 32'h0000_0012;
    localparam logic [WORD_W-1:0] KEY_B_RST       = 32'h0000_0261;
    localparam logic [WORD_W-1:0] KEY_C_RST       = 32'h0000_0084;
    localparam logic [WORD_W-1:0] KEY_D_RST       = 32'h0000_0036;
    localparam logic [WORD_W-1:0] ROUND_DELTA_RST = 32'h0000_8436;
    localparam logic [CNT_W-1:0]  ROUND_COUNT_RST = 7'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_DELTA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 3'd5;

    // Microcode addresses
    localparam logic [UPC_W-1:0] UA_ENC_A = 3'd0;
    localparam logic [UPC_W-1:0] UA_ENC_B = 3'd1;
    localparam logic [UPC_W-1:0] UA_DEC_A = 3'd2;
    localparam logic [UPC_W-1:0] UA_DEC_B = 3'd3;
    localparam logic [UPC_W-1:0] UA_FIN   = 3'd4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_ENC  = 2'd1,
        FUNC_DEC  = 2'd2
    } t_func;

    typedef enum logic {
        WSEL_FIRST,
        WSEL_SECOND
    } t_word_sel;

    typedef enum logic [1:0] {
        SUM_KEEP,
        SUM_PRE_ADD,
        SUM_POST_SUB
    } t_sum_op;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_END
    } t_seq_op;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    typedef struct packed {
        logic       upd_en;
        t_word_sel  word_sel;
        logic       sub;
        t_sum_op    sum_op;
        t_seq_op    seq_op;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic       load_en;
        logic       step_en;
        t_word_sel  word_sel;
        logic       sub;
        t_sum_op    sum_op;
    } t_dp_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

endpackage

`default_nettype wire

FILE: rtl/core/tce_datapath.sv
// ----------------------------------------------------------------------------
// TEA cipher engine datapath
// Word and sum registers with one shared mix unit and add/subtract stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tce_pkg::t_dp_ctrl           i_ctrl,
    input  wire logic [tce_pkg::HALF_W-1:0]  i_load_first,
    input  wire logic [tce_pkg::HALF_W-1:0]  i_load_second,
    input  wire logic [tce_pkg::WORD_W-1:0]  i_key_a,
    input  wire logic [tce_pkg::WORD_W-1:0]  i_key_b,
    input  wire logic [tce_pkg::WORD_W-1:0]  i_key_c,
    input  wire logic [tce_pkg::WORD_W-1:0]  i_key_d,
    input  wire logic [tce_pkg::WORD_W-1:0]  i_round_delta,
    output logic      [tce_pkg::WORD_W-1:0]  o_first,
    output logic      [tce_pkg::WORD_W-1:0]  o_second
);
    import tce_pkg::*;

    logic [WORD_W-1:0] r_first, n_first;
    logic [WORD_W-1:0] r_second, n_second;
    logic [WORD_W-1:0] r_sum, n_sum;

    logic [WORD_W-1:0] sum_pre;
    logic [WORD_W-1:0] sum_use;
    logic [WORD_W-1:0] mix_w;
    logic [WORD_W-1:0] key_l;
    logic [WORD_W-1:0] key_r;
    logic [WORD_W-1:0] mix_val;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] upd;

    // Shared round unit: one word update per step
    always_comb begin
        sum_pre = r_sum + i_round_delta;
        sum_use = (i_ctrl.sum_op == SUM_PRE_ADD) ? sum_pre : r_sum;
        if (i_ctrl.word_sel == WSEL_FIRST) begin
            mix_w = r_second;
            key_l = i_key_a;
            key_r = i_key_b;
            dst   = r_first;
        end else begin
            mix_w = r_first;
            key_l = i_key_c;
            key_r = i_key_d;
            dst   = r_second;
        end
        mix_val = ((mix_w << 4) + key_l) ^ (mix_w + sum_use)
                ^ ({{5{mix_w[WORD_W-1]}}, mix_w[WORD_W-1:5]} + key_r);
        upd     = i_ctrl.sub ? (dst - mix_val) : (dst + mix_val);
    end

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_sum    = r_sum;
        if (i_ctrl.load_en) begin
            n_first  = {{(WORD_W-HALF_W){1'b0}}, i_load_first};
            n_second = {{(WORD_W-HALF_W){1'b0}}, i_load_second};
        end else if (i_ctrl.step_en) begin
            if (i_ctrl.word_sel == WSEL_FIRST) begin
                n_first = upd;
            end else begin
                n_second = upd;
            end
            case (i_ctrl.sum_op)
                SUM_PRE_ADD:  n_sum = sum_pre;
                SUM_POST_SUB: n_sum = r_sum - i_round_delta;
                default:      n_sum = r_sum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_sum    <= '0;
        end else begin
            r_first  <= n_first;
            r_second <= n_second;
            r_sum    <= n_sum;
        end
    end

    assign o_first  = r_first;
    assign o_second = r_second;

endmodule

`default_nettype wire

FILE: rtl/core/tce_useq.sv
// ----------------------------------------------------------------------------
// TEA cipher engine microsequencer
// Control ROM, micro program counter, round counter and run/idle control.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_useq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tce_pkg::FUNC_W-1:0] i_func,
    input  wire logic [tce_pkg::CNT_W-1:0]  i_round_count,
    input  wire logic                       i_out_free,
    output tce_pkg::t_dp_ctrl               o_dp_ctrl,
    output tce_pkg::t_seq_status            o_status
);
    import tce_pkg::*;

    t_seq_state        r_state, n_state;
    logic [UPC_W-1:0]  r_upc, n_upc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    t_uword            uword;
    logic [CNT_W-1:0]  rounds;
    logic              more;
    logic              run;

    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{upd_en: 1'b0, word_sel: WSEL_FIRST, sub: 1'b0, sum_op: SUM_KEEP,
              seq_op: SEQ_END, target: UA_FIN};
        case (addr)
            UA_ENC_A: w = '{upd_en: 1'b1, word_sel: WSEL_FIRST, sub: 1'b0,
                            sum_op: SUM_PRE_ADD, seq_op: SEQ_NEXT, target: UA_ENC_B};
            UA_ENC_B: w = '{upd_en: 1'b1, word_sel: WSEL_SECOND, sub: 1'b0,
                            sum_op: SUM_KEEP, seq_op: SEQ_LOOP, target: UA_ENC_A};
            UA_DEC_A: w = '{upd_en: 1'b1, word_sel: WSEL_SECOND, sub: 1'b1,
                            sum_op: SUM_KEEP, seq_op: SEQ_NEXT, target: UA_DEC_B};
            UA_DEC_B: w = '{upd_en: 1'b1, word_sel: WSEL_FIRST, sub: 1'b1,
                            sum_op: SUM_POST_SUB, seq_op: SEQ_LOOP, target: UA_DEC_A};
            default:  w = '{upd_en: 1'b0, word_sel: WSEL_FIRST, sub: 1'b0,
                            sum_op: SUM_KEEP, seq_op: SEQ_END, target: UA_FIN};
        endcase
        return w;
    endfunction

    assign uword  = ucode(r_upc);
    assign rounds = (i_round_count > MAX_ROUNDS) ? MAX_ROUNDS : i_round_count;
    assign more   = (r_cnt > 7'd1);
    assign run    = (r_state == ST_RUN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_RUN;
            ST_RUN:  if (uword.seq_op == SEQ_END && i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Program counter and round counter
    always_comb begin
        n_upc = r_upc;
        n_cnt = r_cnt;
        if (!run) begin
            if (i_start) begin
                n_cnt = rounds;
                case (i_func)
                    FUNC_ENC: n_upc = (rounds == '0) ? UA_FIN : UA_ENC_A;
                    FUNC_DEC: n_upc = (rounds == '0) ? UA_FIN : UA_DEC_A;
                    default:  n_upc = UA_FIN;
                endcase
            end
        end else begin
            case (uword.seq_op)
                SEQ_NEXT: n_upc = uword.target;
                SEQ_LOOP: begin
                    n_cnt = r_cnt - 7'd1;
                    n_upc = more ? uword.target : UA_FIN;
                end
                default:  n_upc = r_upc;
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_dp_ctrl.load_en  = i_start && !run && (i_func == FUNC_LOAD);
        o_dp_ctrl.step_en  = run && uword.upd_en;
        o_dp_ctrl.word_sel = uword.word_sel;
        o_dp_ctrl.sub      = uword.sub;
        o_dp_ctrl.sum_op   = uword.sum_op;
        o_status.busy      = run;
        o_status.done      = run && (uword.seq_op == SEQ_END) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_upc   <= UA_FIN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tea_cipher_engine_top.sv
// ----------------------------------------------------------------------------
// TEA cipher engine top level
// Config registers, input/output handshakes, microsequencer and datapath.
// ----------------------------------------------------------------------------
// The engine holds two 32-bit words and a running round sum that persists
// across transactions. A load transaction (func 0) writes the two 16-bit
// inputs, zero-extended, into the words; encrypt (func 1) and decrypt
// (func 2) run min(round_count, 64) Feistel rounds; func 3 leaves everything
// as is. Every input transaction yields exactly one output transaction with
// the two words after the operation. One transaction is worked on at a time;
// a new one is accepted only once the sequencer is idle again. Encrypt and
// decrypt use the single shared round unit, which performs one of the two
// dependent word updates of a round per micro step. A finished result sits
// in the output register while the next transaction is accepted; a further
// result is only held back if it completes before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_cipher_engine_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tce_pkg::WORD_W-1:0]    i_cfg_wdata,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [tce_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [tce_pkg::HALF_W-1:0]    i_load_first,
    input  wire logic [tce_pkg::HALF_W-1:0]    i_load_second,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [tce_pkg::WORD_W-1:0]  o_word_first,
    output logic signed [tce_pkg::WORD_W-1:0]  o_word_second
);
    import tce_pkg::*;

    // Configuration registers
    logic [WORD_W-1:0] r_key_a;
    logic [WORD_W-1:0] r_key_b;
    logic [WORD_W-1:0] r_key_c;
    logic [WORD_W-1:0] r_key_d;
    logic [WORD_W-1:0] r_round_delta;
    logic [CNT_W-1:0]  r_round_count;

    // Output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word_first;
    logic [WORD_W-1:0] r_word_second;

    logic              in_acc;
    logic              out_free;
    t_dp_ctrl          dp_ctrl;
    t_seq_status       seq_status;
    logic [WORD_W-1:0] dp_first;
    logic [WORD_W-1:0] dp_second;

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a       <= KEY_A_RST;
            r_key_b       <= KEY_B_RST;
            r_key_c       <= KEY_C_RST;
            r_key_d       <= KEY_D_RST;
            r_round_delta <= ROUND_DELTA_RST;
            r_round_count <= ROUND_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY_A:       r_key_a       <= i_cfg_wdata;
                CFG_KEY_B:       r_key_b       <= i_cfg_wdata;
                CFG_KEY_C:       r_key_c       <= i_cfg_wdata;
                CFG_KEY_D:       r_key_d       <= i_cfg_wdata;
                CFG_ROUND_DELTA: r_round_delta <= i_cfg_wdata;
                CFG_ROUND_COUNT: r_round_count <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept only while the sequencer is idle
    assign o_in_stall = seq_status.busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Output slot is free when empty or draining this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    tce_useq u_useq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc),
        .i_func        (i_func),
        .i_round_count (r_round_count),
        .i_out_free    (out_free),
        .o_dp_ctrl     (dp_ctrl),
        .o_status      (seq_status)
    );

    tce_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (dp_ctrl),
        .i_load_first  (i_load_first),
        .i_load_second (i_load_second),
        .i_key_a       (r_key_a),
        .i_key_b       (r_key_b),
        .i_key_c       (r_key_c),
        .i_key_d       (r_key_d),
        .i_round_delta (r_round_delta),
        .o_first       (dp_first),
        .o_second      (dp_second)
    );

    // Capture the words when the program ends; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_status.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_status.done) begin
            r_word_first  <= dp_first;
            r_word_second <= dp_second;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_first  = r_word_first;
    assign o_word_second = r_word_second;

    // An accepted transaction keeps the input side closed in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accept");

    // Words hold while idle with nothing accepted
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!seq_status.busy && !in_acc) |=> ($stable(dp_first) && $stable(dp_second)))
        else $error("words changed while idle");

    // Program end always presents a result in the next cycle
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_status.done |=> (o_out_valid && !o_in_stall))
        else $error("finished program without result");

endmodule

`default_nettype wire
